[rtl/vdjs_pkg.sv]
package vdjs_pkg;

    localparam int JOB_DEPTH = 16;
    localparam int PAD_COUNT = 4;

    // count holds 0..JOB_DEPTH, index addresses the store
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
    localparam int JOB_IDX_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_ADDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ADDR = 1'b1;

    localparam logic [2:0] REQ_TILES      = 3'd0;
    localparam logic [2:0] REQ_MAP        = 3'd1;
    localparam logic [2:0] REQ_SPRITES    = 3'd2;
    localparam logic [2:0] REQ_PALETTE    = 3'd3;
    localparam logic [2:0] REQ_VBLANK     = 3'd4;
    localparam logic [2:0] REQ_TIMER_RST  = 3'd5;
    localparam logic [2:0] REQ_CLEAR_PAD  = 3'd6;

    localparam logic [1:0] KIND_SPRITE  = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_VRAM    = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [15:0] SPRITE_SIZE  = 16'h0220;
    localparam logic [15:0] PALETTE_SIZE = 16'h0200;
    localparam logic [15:0] MAP_SIZE     = 16'h0800;

    typedef struct packed {
        logic [23:0] src;
        logic [15:0] dest;
        logic [15:0] size;
    } job_t;

    typedef struct packed {
        logic accept;
        logic load_sprite;
        logic load_palette;
        logic load_job;
        logic load_done;
    } dp_cmd_t;

    typedef struct packed {
        logic vblank_req;
        logic sprite_pending;
        logic palette_pending;
        logic jobs_left;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/vdjs_ctrl.sv]
module vdjs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  vdjs_pkg::dp_stat_t stat,
    output vdjs_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SPRITE  = 3'd1;
    localparam logic [2:0] ST_PALETTE = 3'd2;
    localparam logic [2:0] ST_JOB_RD  = 3'd3;
    localparam logic [2:0] ST_JOB_OUT = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && stat.vblank_req)
                begin
                    state_next = ST_SPRITE;
                end
            end
            ST_SPRITE:
            begin
                if (!stat.sprite_pending)
                begin
                    state_next = ST_PALETTE;
                end
                else if (stat.out_free)
                begin
                    cmd.load_sprite = 1'b1;
                    state_next      = ST_PALETTE;
                end
            end
            ST_PALETTE:
            begin
                if (!stat.palette_pending)
                begin
                    state_next = ST_JOB_RD;
                end
                else if (stat.out_free)
                begin
                    cmd.load_palette = 1'b1;
                    state_next       = ST_JOB_RD;
                end
            end
            ST_JOB_RD:
            begin
                // store read data is registered, so it is valid in the cycle after the index settles
                state_next = stat.jobs_left ? ST_JOB_OUT : ST_DONE;
            end
            ST_JOB_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_job = 1'b1;
                    state_next   = ST_JOB_RD;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/vdjs_dp.sv]
module vdjs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vdjs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vdjs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [2:0]                          req_type,
    input  logic [5:0]                          base_block,
    input  logic [23:0]                         source_address,
    input  logic [15:0]                         job_size,
    input  logic [15:0]                         pad_sample_a,
    input  logic [15:0]                         pad_sample_b,
    input  logic [15:0]                         pad_sample_c,
    input  logic [15:0]                         pad_sample_d,
    input  logic [1:0]                          pad_select,
    input  vdjs_pkg::dp_cmd_t                   cmd,
    output vdjs_pkg::dp_stat_t                  stat,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [1:0]                          launch_kind,
    output logic [23:0]                         launch_source,
    output logic [15:0]                         launch_dest,
    output logic [15:0]                         launch_size,
    output logic [15:0]                         pad_held_a,
    output logic [15:0]                         pad_held_b,
    output logic [15:0]                         pad_held_c,
    output logic [15:0]                         pad_held_d,
    output logic [15:0]                         frame_timer,
    output logic                                last_of_frame
);

    logic [23:0] sprite_addr_reg;
    logic [23:0] palette_addr_reg;

    logic sprite_pending_reg;
    logic palette_pending_reg;
    logic [vdjs_pkg::JOB_CNT_W-1:0] job_count_reg;
    logic [vdjs_pkg::JOB_CNT_W-1:0] rd_idx_reg;

    vdjs_pkg::job_t job_mem [vdjs_pkg::JOB_DEPTH];
    vdjs_pkg::job_t job_q;
    vdjs_pkg::job_t new_job;

    logic [15:0] pad_held_reg [4];
    logic [15:0] pad_sample   [4];
    logic        timer_on_reg;
    logic [15:0] timer0_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [23:0] src_reg;
    logic [15:0] dest_reg;
    logic [15:0] size_reg;
    logic [15:0] held_out_reg [4];
    logic [15:0] timer_out_reg;
    logic        last_reg;

    logic is_vblank;
    logic push;
    logic out_free;
    logic any_load;

    assign pad_sample[0] = pad_sample_a;
    assign pad_sample[1] = pad_sample_b;
    assign pad_sample[2] = pad_sample_c;
    assign pad_sample[3] = pad_sample_d;

    assign is_vblank = cmd.accept && (req_type == vdjs_pkg::REQ_VBLANK);
    assign push = cmd.accept
                  && (req_type == vdjs_pkg::REQ_TILES || req_type == vdjs_pkg::REQ_MAP)
                  && (job_count_reg < vdjs_pkg::JOB_CNT_W'(vdjs_pkg::JOB_DEPTH));

    assign out_free = !out_valid_reg || !out_stall;
    assign any_load = cmd.load_sprite || cmd.load_palette || cmd.load_job || cmd.load_done;

    assign stat.vblank_req      = (req_type == vdjs_pkg::REQ_VBLANK);
    assign stat.sprite_pending  = sprite_pending_reg;
    assign stat.palette_pending = palette_pending_reg;
    assign stat.jobs_left       = (rd_idx_reg < job_count_reg);
    assign stat.out_free        = out_free;

    // tiles land one 4K block past the given one; map jobs sit on 1K blocks
    always_comb
    begin
        new_job.src = source_address;
        if (req_type == vdjs_pkg::REQ_MAP)
        begin
            new_job.dest = {base_block, 10'b0};
            new_job.size = vdjs_pkg::MAP_SIZE;
        end
        else
        begin
            new_job.dest = {base_block[3:0] + 4'd1, 12'b0};
            new_job.size = job_size;
        end
    end

    // job store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_mem[job_count_reg[vdjs_pkg::JOB_IDX_W-1:0]] <= new_job;
        end
        job_q <= job_mem[rd_idx_reg[vdjs_pkg::JOB_IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_addr_reg     <= '0;
            palette_addr_reg    <= '0;
            sprite_pending_reg  <= 1'b0;
            palette_pending_reg <= 1'b0;
            job_count_reg       <= '0;
            rd_idx_reg          <= '0;
            timer_on_reg        <= 1'b0;
            timer0_reg          <= '0;
            for (int i = 0; i < 4; i++)
            begin
                pad_held_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vdjs_pkg::REG_SPRITE_ADDR:  sprite_addr_reg  <= cfg_data;
                    vdjs_pkg::REG_PALETTE_ADDR: palette_addr_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (push)
            begin
                job_count_reg <= job_count_reg + 1'b1;
            end
            if (cmd.accept && req_type == vdjs_pkg::REQ_SPRITES)
            begin
                sprite_pending_reg <= 1'b1;
            end
            if (cmd.accept && req_type == vdjs_pkg::REQ_PALETTE)
            begin
                palette_pending_reg <= 1'b1;
            end
            if (cmd.accept && req_type == vdjs_pkg::REQ_TIMER_RST)
            begin
                timer_on_reg <= 1'b1;
                timer0_reg   <= '0;
            end

            // pads and timer settle at vblank accept; the frame-done word
            // picks them up after the launches drain
            if (is_vblank)
            begin
                rd_idx_reg <= '0;
                if (timer_on_reg)
                begin
                    timer0_reg <= timer0_reg + 16'd1;
                end
            end

            for (int i = 0; i < 4; i++)
            begin
                if (i < vdjs_pkg::PAD_COUNT)
                begin
                    if (is_vblank)
                    begin
                        pad_held_reg[i] <= pad_held_reg[i] | pad_sample[i];
                    end
                    else if (cmd.accept && req_type == vdjs_pkg::REQ_CLEAR_PAD
                             && pad_select == 2'(i))
                    begin
                        pad_held_reg[i] <= '0;
                    end
                end
            end

            if (cmd.load_sprite)
            begin
                sprite_pending_reg <= 1'b0;
            end
            if (cmd.load_palette)
            begin
                palette_pending_reg <= 1'b0;
            end
            if (cmd.load_job)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.load_done)
            begin
                job_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (any_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (any_load)
        begin
            kind_reg      <= vdjs_pkg::KIND_DONE;
            src_reg       <= '0;
            dest_reg      <= '0;
            size_reg      <= '0;
            timer_out_reg <= '0;
            last_reg      <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                held_out_reg[i] <= '0;
            end
            if (cmd.load_sprite)
            begin
                kind_reg <= vdjs_pkg::KIND_SPRITE;
                src_reg  <= sprite_addr_reg;
                size_reg <= vdjs_pkg::SPRITE_SIZE;
            end
            else if (cmd.load_palette)
            begin
                kind_reg <= vdjs_pkg::KIND_PALETTE;
                src_reg  <= palette_addr_reg;
                size_reg <= vdjs_pkg::PALETTE_SIZE;
            end
            else if (cmd.load_job)
            begin
                kind_reg <= vdjs_pkg::KIND_VRAM;
                src_reg  <= job_q.src;
                dest_reg <= job_q.dest;
                size_reg <= job_q.size;
            end
            else
            begin
                timer_out_reg <= timer0_reg;
                last_reg      <= 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    held_out_reg[i] <= pad_held_reg[i];
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign launch_kind   = kind_reg;
    assign launch_source = src_reg;
    assign launch_dest   = dest_reg;
    assign launch_size   = size_reg;
    assign pad_held_a    = held_out_reg[0];
    assign pad_held_b    = held_out_reg[1];
    assign pad_held_c    = held_out_reg[2];
    assign pad_held_d    = held_out_reg[3];
    assign frame_timer   = timer_out_reg;
    assign last_of_frame = last_reg;

endmodule

[rtl/vblank_dma_job_scheduler_top.sv]
// Video DMA job scheduler. Tile, map, sprite, palette, timer and pad requests
// produce no output word. A vblank request drains the frame: sprite launch
// (if pending), palette launch (if pending), each queued VRAM job oldest
// first, then a frame-done word with the sticky pad words and timer 0. The
// input stalls for the whole drain, while the controller walks the job store
// through its single registered read port, reading each job and then
// launching it. Jobs beyond the 16-entry queue are dropped. Configuration
// writes are registered and must be made while idle.
module vblank_dma_job_scheduler_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vdjs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vdjs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       req_type,
    input  logic [5:0]                       base_block,
    input  logic [23:0]                      source_address,
    input  logic [15:0]                      job_size,
    input  logic [15:0]                      pad_sample_a,
    input  logic [15:0]                      pad_sample_b,
    input  logic [15:0]                      pad_sample_c,
    input  logic [15:0]                      pad_sample_d,
    input  logic [1:0]                       pad_select,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       launch_kind,
    output logic [23:0]                      launch_source,
    output logic [15:0]                      launch_dest,
    output logic [15:0]                      launch_size,
    output logic [15:0]                      pad_held_a,
    output logic [15:0]                      pad_held_b,
    output logic [15:0]                      pad_held_c,
    output logic [15:0]                      pad_held_d,
    output logic [15:0]                      frame_timer,
    output logic                             last_of_frame
);

    vdjs_pkg::dp_cmd_t  cmd;
    vdjs_pkg::dp_stat_t stat;

    vdjs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    vdjs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .base_block     (base_block),
        .source_address (source_address),
        .job_size       (job_size),
        .pad_sample_a   (pad_sample_a),
        .pad_sample_b   (pad_sample_b),
        .pad_sample_c   (pad_sample_c),
        .pad_sample_d   (pad_sample_d),
        .pad_select     (pad_select),
        .cmd            (cmd),
        .stat           (stat),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .launch_kind    (launch_kind),
        .launch_source  (launch_source),
        .launch_dest    (launch_dest),
        .launch_size    (launch_size),
        .pad_held_a     (pad_held_a),
        .pad_held_b     (pad_held_b),
        .pad_held_c     (pad_held_c),
        .pad_held_d     (pad_held_d),
        .frame_timer    (frame_timer),
        .last_of_frame  (last_of_frame)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 50;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]       req;
        logic [5:0]       block;
        logic [23:0]      src;
        logic [15:0]      size;
        logic [3:0][15:0] pad;
        logic [1:0]       sel;
    } request_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [23:0]      src;
        logic [15:0]      dest;
        logic [15:0]      size;
        logic [3:0][15:0] held;
        logic [15:0]      timer;
        logic             last;
    } launch_t;

    class launch_scoreboard;
        logic [23:0]      sprite_addr;
        logic [23:0]      palette_addr;
        bit               sprite_pending;
        bit               palette_pending;
        vdjs_pkg::job_t   vram_jobs[$];
        logic [3:0][15:0] held;
        bit               timer0_on;
        logic [15:0]      timer0;
        launch_t          expected_launches[$];
        int               errors;

        function new();
            sprite_addr     = '0;
            palette_addr    = '0;
            sprite_pending  = 1'b0;
            palette_pending = 1'b0;
            held            = '0;
            timer0_on       = 1'b0;
            timer0          = '0;
            errors          = 0;
        endfunction

        function void set_reg(logic [vdjs_pkg::CFG_IDX_W-1:0] idx,
                              logic [vdjs_pkg::CFG_DATA_W-1:0] data);
            if (idx == vdjs_pkg::REG_SPRITE_ADDR)
                sprite_addr = data;
            else
                palette_addr = data;
        endfunction

        function void queue_launch(logic [1:0] kind, logic [23:0] src,
                                   logic [15:0] dest, logic [15:0] size);
            launch_t l;
            l      = '0;
            l.kind = kind;
            l.src  = src;
            l.dest = dest;
            l.size = size;
            expected_launches.push_back(l);
        endfunction

        function void predict_request(request_t r);
            vdjs_pkg::job_t j;
            launch_t        l;
            case (r.req)
                vdjs_pkg::REQ_TILES, vdjs_pkg::REQ_MAP:
                begin
                    // full queue drops the job
                    if (vram_jobs.size() < vdjs_pkg::JOB_DEPTH)
                    begin
                        j.src = r.src;
                        if (r.req == vdjs_pkg::REQ_TILES)
                        begin
                            // (block+1)<<12 kept to 16 bits
                            j.dest = {r.block[3:0] + 4'd1, 12'h000};
                            j.size = r.size;
                        end
                        else
                        begin
                            j.dest = {r.block, 10'h000};
                            j.size = vdjs_pkg::MAP_SIZE;
                        end
                        vram_jobs.push_back(j);
                    end
                end
                vdjs_pkg::REQ_SPRITES:   sprite_pending = 1'b1;
                vdjs_pkg::REQ_PALETTE:   palette_pending = 1'b1;
                vdjs_pkg::REQ_VBLANK:
                begin
                    if (sprite_pending)
                        queue_launch(vdjs_pkg::KIND_SPRITE, sprite_addr, '0,
                                     vdjs_pkg::SPRITE_SIZE);
                    if (palette_pending)
                        queue_launch(vdjs_pkg::KIND_PALETTE, palette_addr, '0,
                                     vdjs_pkg::PALETTE_SIZE);
                    foreach (vram_jobs[i])
                        queue_launch(vdjs_pkg::KIND_VRAM, vram_jobs[i].src,
                                     vram_jobs[i].dest, vram_jobs[i].size);
                    sprite_pending  = 1'b0;
                    palette_pending = 1'b0;
                    vram_jobs.delete();
                    for (int i = 0; i < vdjs_pkg::PAD_COUNT; i++)
                        held[i] = held[i] | r.pad[i];
                    // only a restart ever enables a timer (timer 0), so the enabled
                    // run from timer 0 is timer 0 alone
                    if (timer0_on)
                        timer0 = timer0 + 16'd1;
                    l       = '0;
                    l.kind  = vdjs_pkg::KIND_DONE;
                    l.held  = held;
                    l.timer = timer0;
                    l.last  = 1'b1;
                    expected_launches.push_back(l);
                end
                vdjs_pkg::REQ_TIMER_RST:
                begin
                    timer0_on = 1'b1;
                    timer0    = '0;
                end
                vdjs_pkg::REQ_CLEAR_PAD:
                begin
                    if (r.sel < vdjs_pkg::PAD_COUNT)
                        held[r.sel] = '0;
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [23:0] exp_v, logic [23:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_launch(launch_t got);
            launch_t exp;
            if (expected_launches.size() == 0)
            begin
                $display("%0t: launch word with none expected: kind %0d src %h dest %h",
                         $time, got.kind, got.src, got.dest);
                errors++;
                return;
            end
            exp = expected_launches.pop_front();
            check_field("launch_kind", exp.kind, got.kind);
            check_field("launch_source", exp.src, got.src);
            check_field("launch_dest", exp.dest, got.dest);
            check_field("launch_size", exp.size, got.size);
            check_field("pad_held_a", exp.held[0], got.held[0]);
            check_field("pad_held_b", exp.held[1], got.held[1]);
            check_field("pad_held_c", exp.held[2], got.held[2]);
            check_field("pad_held_d", exp.held[3], got.held[3]);
            check_field("frame_timer", exp.timer, got.timer);
            check_field("last_of_frame", exp.last, got.last);
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [vdjs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vdjs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [2:0]                      req_type = '0;
    logic [5:0]                      base_block = '0;
    logic [23:0]                     source_address = '0;
    logic [15:0]                     job_size = '0;
    logic [15:0]                     pad_sample_a = '0;
    logic [15:0]                     pad_sample_b = '0;
    logic [15:0]                     pad_sample_c = '0;
    logic [15:0]                     pad_sample_d = '0;
    logic [1:0]                      pad_select = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      launch_kind;
    logic [23:0]                     launch_source;
    logic [15:0]                     launch_dest;
    logic [15:0]                     launch_size;
    logic [15:0]                     pad_held_a;
    logic [15:0]                     pad_held_b;
    logic [15:0]                     pad_held_c;
    logic [15:0]                     pad_held_d;
    logic [15:0]                     frame_timer;
    logic                            last_of_frame;

    launch_scoreboard board = new();
    launch_t          seen;
    bit               steady = 1'b0;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int               items_sent = 0;
    logic             in_take;
    logic             out_take;

    assign seen = {launch_kind, launch_source, launch_dest, launch_size,
                   pad_held_d, pad_held_c, pad_held_b, pad_held_a,
                   frame_timer, last_of_frame};
    assign in_take  = in_valid & ~in_stall;
    assign out_take = out_valid & ~out_stall;

    vblank_dma_job_scheduler_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .base_block     (base_block),
        .source_address (source_address),
        .job_size       (job_size),
        .pad_sample_a   (pad_sample_a),
        .pad_sample_b   (pad_sample_b),
        .pad_sample_c   (pad_sample_c),
        .pad_sample_d   (pad_sample_d),
        .pad_select     (pad_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .launch_kind    (launch_kind),
        .launch_source  (launch_source),
        .launch_dest    (launch_dest),
        .launch_size    (launch_size),
        .pad_held_a     (pad_held_a),
        .pad_held_b     (pad_held_b),
        .pad_held_c     (pad_held_c),
        .pad_held_d     (pad_held_d),
        .frame_timer    (frame_timer),
        .last_of_frame  (last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_take)
            board.check_launch(seen);
    end

    // output back-pressure: free runs, short stalls, an occasional long one
    always @(posedge clk)
    begin
        if (steady)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(10, 30);
                end
                1, 2, 3:
                begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                default:
                begin
                    out_stall  <= 1'b0;
                    stall_left <= $urandom_range(0, 12);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || in_take || out_take)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("vblank_dma_job_scheduler_top test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic request_t rand_req(logic [2:0] req);
        request_t r;
        r.req   = req;
        r.block = 6'($urandom);
        r.src   = 24'($urandom);
        r.size  = 16'($urandom);
        // mostly single buttons so the sticky words do not saturate at once
        for (int i = 0; i < 4; i++)
            r.pad[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'd1 << $urandom_range(0, 15);
        r.sel   = 2'($urandom);
        return r;
    endfunction

    task automatic pause_sender();
        int n;
        n = 0;
        if (!steady)
        begin
            case ($urandom_range(0, 19))
                0:                      n = $urandom_range(10, 30);
                1, 2, 3, 4, 5, 6, 7, 8: n = $urandom_range(1, 3);
                default:                n = 0;
            endcase
        end
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_req(request_t r);
        in_valid       <= 1'b1;
        req_type       <= r.req;
        base_block     <= r.block;
        source_address <= r.src;
        job_size       <= r.size;
        pad_sample_a   <= r.pad[0];
        pad_sample_b   <= r.pad[1];
        pad_sample_c   <= r.pad[2];
        pad_sample_d   <= r.pad[3];
        pad_select     <= r.sel;
        do
            @(posedge clk);
        while (in_stall);
        board.predict_request(r);
        items_sent++;
        pause_sender();
    endtask

    // hold the sender until every expected word is out and the block has settled
    task automatic flush_launches();
        if (in_valid)
            in_valid <= 1'b0;
        while (board.expected_launches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [vdjs_pkg::CFG_DATA_W-1:0] sprite_src,
                              logic [vdjs_pkg::CFG_DATA_W-1:0] palette_src);
        cfg_we    <= 1'b1;
        cfg_index <= vdjs_pkg::REG_SPRITE_ADDR;
        cfg_data  <= sprite_src;
        @(posedge clk);
        cfg_index <= vdjs_pkg::REG_PALETTE_ADDR;
        cfg_data  <= palette_src;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(vdjs_pkg::REG_SPRITE_ADDR, sprite_src);
        board.set_reg(vdjs_pkg::REG_PALETTE_ADDR, palette_src);
    endtask

    // one frame: n requests (job_pct percent of them queue jobs), then vblank
    task automatic random_frame(int n, int job_pct);
        logic [2:0] pick;
        repeat (n)
        begin
            if ($urandom_range(1, 100) <= job_pct)
            begin
                pick = $urandom_range(0, 1) ? vdjs_pkg::REQ_MAP : vdjs_pkg::REQ_TILES;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       pick = vdjs_pkg::REQ_SPRITES;
                    1:       pick = vdjs_pkg::REQ_PALETTE;
                    2:       pick = vdjs_pkg::REQ_TIMER_RST;
                    3:       pick = vdjs_pkg::REQ_CLEAR_PAD;
                    default: pick = REQ_UNUSED;
                endcase
            end
            send_req(rand_req(pick));
        end
        send_req(rand_req(vdjs_pkg::REQ_VBLANK));
        if ($urandom_range(0, 7) == 0)
            flush_launches();
    endtask

    initial
    begin
        request_t r;
        int       target;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(24'hFF_FFFF, 24'h00_0000);

        // empty frame, then the sticky words cleared one by one
        r = rand_req(vdjs_pkg::REQ_VBLANK);
        r.pad = {4{16'hFFFF}};
        send_req(r);
        for (int s = 0; s < 4; s++)
        begin
            r = rand_req(vdjs_pkg::REQ_CLEAR_PAD);
            r.sel = 2'(s);
            send_req(r);
        end
        send_req(rand_req(vdjs_pkg::REQ_TIMER_RST));
        r = rand_req(vdjs_pkg::REQ_TILES);
        r.block = 6'd0;
        r.src = 24'h00_0000;
        r.size = 16'h0000;
        send_req(r);
        // block 63 tile destination wraps past 16 bits
        r = rand_req(vdjs_pkg::REQ_TILES);
        r.block = 6'd63;
        r.src = 24'hFF_FFFF;
        r.size = 16'hFFFF;
        send_req(r);
        r = rand_req(vdjs_pkg::REQ_TILES);
        r.block = 6'd14;
        send_req(r);
        r = rand_req(vdjs_pkg::REQ_MAP);
        r.block = 6'd0;
        r.src = 24'h00_0000;
        send_req(r);
        r = rand_req(vdjs_pkg::REQ_MAP);
        r.block = 6'd63;
        r.src = 24'hFF_FFFF;
        send_req(r);
        send_req(rand_req(vdjs_pkg::REQ_SPRITES));
        send_req(rand_req(vdjs_pkg::REQ_PALETTE));
        send_req(rand_req(REQ_UNUSED));
        r = rand_req(vdjs_pkg::REQ_VBLANK);
        r.pad = '0;
        send_req(r);
        send_req(rand_req(vdjs_pkg::REQ_SPRITES));
        send_req(rand_req(vdjs_pkg::REQ_VBLANK));
        send_req(rand_req(vdjs_pkg::REQ_PALETTE));
        send_req(rand_req(vdjs_pkg::REQ_VBLANK));
        send_req(rand_req(vdjs_pkg::REQ_CLEAR_PAD));
        send_req(rand_req(vdjs_pkg::REQ_VBLANK));

        for (int phase = 0; phase < 4; phase++)
        begin
            flush_launches();
            case (phase)
                0:       set_config(24'h00_0000, 24'hFF_FFFF);
                3:       set_config(24'h00_0000, 24'h00_0000);
                default: set_config(24'($urandom), 24'($urandom));
            endcase
            steady = (phase == 2);
            // first frame overfills the job queue
            random_frame(20, 100);
            target = items_sent + 22;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    random_frame($urandom_range(16, 26), 70);
                else
                    random_frame($urandom_range(0, 7), 70);
            end
        end
        steady = 1'b0;

        flush_launches();
        repeat (END_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.expected_launches.size() == 0)
        begin
            $display("vblank_dma_job_scheduler_top test passed");
        end
        else
        begin
            $display("vblank_dma_job_scheduler_top test failed");
        end
        $finish;
    end

endmodule
